>>> rtl/sts_pkg.sv
// Shared types, token codes and the keyword lookup of the script token scanner.
package sts_pkg;

    localparam int POSITION_BITS = 24;
    localparam int LENGTH_BITS   = 16;
    localparam int LINE_BITS     = 24;
    localparam int PREFIX_BYTES  = 6;
    localparam int PREFIX_BITS   = 8 * PREFIX_BYTES;
    localparam int KW_COUNT      = 16;

    localparam logic [POSITION_BITS-1:0] POS_MAX  = '1;
    localparam logic [LENGTH_BITS-1:0]   LEN_MAX  = '1;
    localparam logic [LINE_BITS-1:0]     LINE_MAX = '1;

    localparam logic [5:0] K_END      = 6'd0;
    localparam logic [5:0] K_ERR      = 6'd1;
    localparam logic [5:0] K_NUM      = 6'd2;
    localparam logic [5:0] K_STR      = 6'd3;
    localparam logic [5:0] K_IDENT    = 6'd4;
    localparam logic [5:0] K_KW0      = 6'd5;
    localparam logic [5:0] K_LPAREN   = 6'd21;
    localparam logic [5:0] K_RPAREN   = 6'd22;
    localparam logic [5:0] K_LBRACE   = 6'd23;
    localparam logic [5:0] K_RBRACE   = 6'd24;
    localparam logic [5:0] K_SEMI     = 6'd25;
    localparam logic [5:0] K_COMMA    = 6'd26;
    localparam logic [5:0] K_DOT      = 6'd27;
    localparam logic [5:0] K_MINUS    = 6'd28;
    localparam logic [5:0] K_PLUS     = 6'd29;
    localparam logic [5:0] K_DIV      = 6'd30;
    localparam logic [5:0] K_MULT     = 6'd31;
    localparam logic [5:0] K_MOD      = 6'd32;
    localparam logic [5:0] K_BANG     = 6'd33;
    localparam logic [5:0] K_BANG_EQ  = 6'd34;
    localparam logic [5:0] K_ASSIGN   = 6'd35;
    localparam logic [5:0] K_EQ_EQ    = 6'd36;
    localparam logic [5:0] K_LT       = 6'd37;
    localparam logic [5:0] K_LE       = 6'd38;
    localparam logic [5:0] K_GT       = 6'd39;
    localparam logic [5:0] K_GE       = 6'd40;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_OPEN_STR   = 2'd2;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } sts_in_t;

    typedef struct packed {
        logic [5:0]               token_kind;
        logic [1:0]               error_code;
        logic [POSITION_BITS-1:0] token_start;
        logic [LENGTH_BITS-1:0]   token_length;
        logic [LINE_BITS-1:0]     line_number;
        logic                     last_of_run;
    } sts_out_t;

    // Keyword text, right aligned, in kind order.
    localparam logic [PREFIX_BITS-1:0] KW_TEXT [KW_COUNT] = '{
        48'h0000_0061_6e64, 48'h0063_6c61_7373, 48'h0000_656c_7365, 48'h0066_616c_7365,
        48'h0000_0066_6f72, 48'h0000_0064_6566, 48'h0000_0000_6966, 48'h0000_6e75_6c6c,
        48'h0000_0000_6f72, 48'h0070_7269_6e74, 48'h7265_7475_726e, 48'h0073_7570_6572,
        48'h0000_7468_6973, 48'h0000_7472_7565, 48'h0000_0076_6172, 48'h0077_6869_6c65
    };

    localparam logic [2:0] KW_LEN [KW_COUNT] = '{
        3'd3, 3'd5, 3'd4, 3'd5, 3'd3, 3'd3, 3'd2, 3'd4,
        3'd2, 3'd5, 3'd6, 3'd5, 3'd4, 3'd4, 3'd3, 3'd5
    };

    function automatic logic [5:0] kw_match(input logic [PREFIX_BITS-1:0] prefix,
                                            input logic [LENGTH_BITS-1:0] len);
        logic [5:0] kind;
        kind = K_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--) begin
            if (len == LENGTH_BITS'(KW_LEN[k]) && prefix == KW_TEXT[k]) begin
                kind = K_KW0 + 6'(k);
            end
        end
        return kind;
    endfunction

endpackage

>>> rtl/sts_lexer.sv
// Scanner state and the single-pass next-state and token logic.
module sts_lexer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step,
    input  sts_pkg::sts_in_t  item,
    output sts_pkg::sts_out_t res0,
    output sts_pkg::sts_out_t res1,
    output logic [1:0]        res_count
);
    import sts_pkg::*;

    localparam logic [7:0] CH_CR = 8'h0D;

    typedef enum logic [11:0] {
        M_IDLE    = 12'b0000_0000_0001,
        M_INT     = 12'b0000_0000_0010,
        M_FRAC    = 12'b0000_0000_0100,
        M_IDENT   = 12'b0000_0000_1000,
        M_STR     = 12'b0000_0001_0000,
        M_ESC     = 12'b0000_0010_0000,
        M_SLASH   = 12'b0000_0100_0000,
        M_COMMENT = 12'b0000_1000_0000,
        M_BANG    = 12'b0001_0000_0000,
        M_EQ      = 12'b0010_0000_0000,
        M_LT      = 12'b0100_0000_0000,
        M_GT      = 12'b1000_0000_0000
    } mode_t;

    mode_t                    mode_reg, mode_next;
    logic [POSITION_BITS-1:0] byte_pos_reg, byte_pos_next;
    logic [POSITION_BITS-1:0] start_reg, start_next;
    logic [LINE_BITS-1:0]     line_reg, line_next;
    logic [PREFIX_BITS-1:0]   prefix_reg, prefix_next;
    logic [LENGTH_BITS-1:0]   run_reg, run_next;

    logic [7:0]               c;
    logic                     is_dig, is_alp;
    logic [LENGTH_BITS-1:0]   ext_len;
    logic [PREFIX_BITS-1:0]   ext_prefix;
    logic [LINE_BITS-1:0]     line_inc;
    logic [5:0]               word_kind, single_kind;
    logic                     idle_go;
    logic                     pv, iv;
    logic [5:0]               pk, ik;
    logic [1:0]               perr, ierr;
    logic [LENGTH_BITS-1:0]   plen, ilen;
    sts_out_t                 pend_tok, idle_tok;

    assign c          = item.char_byte;
    assign is_dig     = c >= "0" && c <= "9";
    assign is_alp     = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_";
    assign ext_len    = (run_reg == LEN_MAX) ? run_reg : run_reg + 1'b1;
    assign ext_prefix = (run_reg < LENGTH_BITS'(PREFIX_BYTES))
                        ? {prefix_reg[PREFIX_BITS-9:0], c} : prefix_reg;
    assign line_inc   = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
    assign word_kind  = kw_match(prefix_reg, run_reg);

    always_comb begin
        case (mode_reg)
            M_SLASH: single_kind = K_DIV;
            M_BANG:  single_kind = K_BANG;
            M_EQ:    single_kind = K_ASSIGN;
            M_LT:    single_kind = K_LT;
            default: single_kind = K_GT;
        endcase
    end

    always_comb begin
        mode_next     = mode_reg;
        byte_pos_next = byte_pos_reg;
        start_next    = start_reg;
        line_next     = line_reg;
        prefix_next   = prefix_reg;
        run_next      = run_reg;
        idle_go       = 1'b0;
        pv            = 1'b0;
        pk            = K_NUM;
        perr          = ERR_NONE;
        plen          = run_reg;
        iv            = 1'b0;
        ik            = K_END;
        ierr          = ERR_NONE;
        ilen          = LENGTH_BITS'(1);

        if (item.end_of_input) begin
            case (mode_reg)
                M_INT, M_FRAC: begin
                    pv = 1'b1;
                    pk = K_NUM;
                end
                M_IDENT: begin
                    pv = 1'b1;
                    pk = word_kind;
                end
                M_STR, M_ESC: begin
                    pv   = 1'b1;
                    pk   = K_ERR;
                    perr = ERR_OPEN_STR;
                end
                M_SLASH, M_BANG, M_EQ, M_LT, M_GT: begin
                    pv = 1'b1;
                    pk = single_kind;
                end
                default: ;
            endcase
            mode_next = M_IDLE;
            iv        = 1'b1;
            ik        = K_END;
            ilen      = '0;
        end else begin
            case (mode_reg)
                M_INT: begin
                    if (is_dig || c == ".") begin
                        prefix_next = ext_prefix;
                        run_next    = ext_len;
                        if (c == ".") mode_next = M_FRAC;
                    end else begin
                        pv      = 1'b1;
                        pk      = K_NUM;
                        idle_go = 1'b1;
                    end
                end
                M_FRAC: begin
                    if (is_dig) begin
                        prefix_next = ext_prefix;
                        run_next    = ext_len;
                    end else begin
                        pv      = 1'b1;
                        pk      = K_NUM;
                        idle_go = 1'b1;
                    end
                end
                M_IDENT: begin
                    if (is_dig || is_alp) begin
                        prefix_next = ext_prefix;
                        run_next    = ext_len;
                    end else begin
                        pv      = 1'b1;
                        pk      = word_kind;
                        idle_go = 1'b1;
                    end
                end
                M_STR: begin
                    prefix_next = ext_prefix;
                    run_next    = ext_len;
                    if (c == "\"") begin
                        pv        = 1'b1;
                        pk        = K_STR;
                        plen      = ext_len;
                        mode_next = M_IDLE;
                    end else if (c == "\\") begin
                        mode_next = M_ESC;
                    end else if (c == "\n") begin
                        line_next = line_inc;
                    end
                end
                M_ESC: begin
                    prefix_next = ext_prefix;
                    run_next    = ext_len;
                    mode_next   = M_STR;
                end
                M_SLASH: begin
                    if (c == "/") begin
                        mode_next = M_COMMENT;
                    end else begin
                        pv      = 1'b1;
                        pk      = K_DIV;
                        idle_go = 1'b1;
                    end
                end
                M_COMMENT: begin
                    if (c == "\n") begin
                        line_next = line_inc;
                        mode_next = M_IDLE;
                    end
                end
                M_BANG, M_EQ, M_LT, M_GT: begin
                    if (c == "=") begin
                        prefix_next = ext_prefix;
                        run_next    = ext_len;
                        pv          = 1'b1;
                        plen        = ext_len;
                        mode_next   = M_IDLE;
                        case (mode_reg)
                            M_BANG:  pk = K_BANG_EQ;
                            M_EQ:    pk = K_EQ_EQ;
                            M_LT:    pk = K_LE;
                            default: pk = K_GE;
                        endcase
                    end else begin
                        pv      = 1'b1;
                        pk      = single_kind;
                        idle_go = 1'b1;
                    end
                end
                default: idle_go = 1'b1;
            endcase

            // Byte seen between tokens
            if (idle_go) begin
                mode_next = M_IDLE;
                if (c == " " || c == "\t" || c == CH_CR) begin
                    mode_next = M_IDLE;
                end else if (c == "\n") begin
                    line_next = line_inc;
                end else if (is_dig || is_alp || c == "\"" || c == "/" || c == "!" ||
                             c == "=" || c == "<" || c == ">") begin
                    start_next  = byte_pos_reg;
                    run_next    = LENGTH_BITS'(1);
                    prefix_next = PREFIX_BITS'(c);
                    if (is_dig)        mode_next = M_INT;
                    else if (is_alp)   mode_next = M_IDENT;
                    else if (c == "\"") mode_next = M_STR;
                    else if (c == "/") mode_next = M_SLASH;
                    else if (c == "!") mode_next = M_BANG;
                    else if (c == "=") mode_next = M_EQ;
                    else if (c == "<") mode_next = M_LT;
                    else               mode_next = M_GT;
                end else begin
                    iv = 1'b1;
                    case (c)
                        "(":     ik = K_LPAREN;
                        ")":     ik = K_RPAREN;
                        "{":     ik = K_LBRACE;
                        "}":     ik = K_RBRACE;
                        ";":     ik = K_SEMI;
                        ",":     ik = K_COMMA;
                        ".":     ik = K_DOT;
                        "-":     ik = K_MINUS;
                        "+":     ik = K_PLUS;
                        "*":     ik = K_MULT;
                        "%":     ik = K_MOD;
                        default: begin
                            ik   = K_ERR;
                            ierr = ERR_UNEXPECTED;
                        end
                    endcase
                end
            end

            if (byte_pos_reg != POS_MAX) byte_pos_next = byte_pos_reg + 1'b1;
        end
    end

    always_comb begin
        pend_tok.token_kind   = pk;
        pend_tok.error_code   = perr;
        pend_tok.token_start  = start_reg;
        pend_tok.token_length = plen;
        pend_tok.line_number  = line_reg;
        pend_tok.last_of_run  = !iv;

        idle_tok.token_kind   = ik;
        idle_tok.error_code   = ierr;
        idle_tok.token_start  = byte_pos_reg;
        idle_tok.token_length = ilen;
        idle_tok.line_number  = line_reg;
        idle_tok.last_of_run  = 1'b1;

        res0      = pv ? pend_tok : idle_tok;
        res1      = idle_tok;
        res_count = {1'b0, pv} + {1'b0, iv};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg     <= M_IDLE;
            byte_pos_reg <= '0;
            start_reg    <= '0;
            line_reg     <= '0;
            prefix_reg   <= '0;
            run_reg      <= '0;
        end else if (step) begin
            mode_reg     <= mode_next;
            byte_pos_reg <= byte_pos_next;
            start_reg    <= start_next;
            line_reg     <= line_next;
            prefix_reg   <= prefix_next;
            run_reg      <= run_next;
        end
    end

endmodule

>>> rtl/sts_res_fifo.sv
// Four-entry result queue taking up to two tokens and giving one per cycle while m_ready is high.
module sts_res_fifo (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic [1:0]        push_count,
    input  sts_pkg::sts_out_t push0,
    input  sts_pkg::sts_out_t push1,
    output logic              room2,
    output logic              m_valid,
    input  logic              m_ready,
    output sts_pkg::sts_out_t m_data
);
    import sts_pkg::*;

    sts_out_t   mem_reg [4];
    logic [1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0] wr_ptr_reg, wr_ptr_next;
    logic [2:0] count_reg, count_next;
    logic       pop;

    assign room2   = count_reg <= 3'd2;
    assign m_valid = count_reg != 3'd0;
    assign m_data  = mem_reg[rd_ptr_reg];
    assign pop     = m_valid && m_ready;

    assign rd_ptr_next = rd_ptr_reg + {1'b0, pop};
    assign wr_ptr_next = wr_ptr_reg + push_count;
    assign count_next  = count_reg + {1'b0, push_count} - {2'b0, pop};

    always_ff @(posedge aclk) begin
        if (push_count != 2'd0) mem_reg[wr_ptr_reg] <= push0;
        if (push_count == 2'd2) mem_reg[wr_ptr_reg + 2'd1] <= push1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            rd_ptr_reg <= rd_ptr_next;
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 3'd4)
        else $error("result queue overfilled");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push_count != 2'd0 |-> count_reg <= 3'd2)
        else $error("push without room");

    a_push_count: assert property (@(posedge aclk) disable iff (!aresetn)
        push_count != 2'd3)
        else $error("more than two tokens from one transaction");

    a_last_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        push_count == 2'd2 |-> !push0.last_of_run && push1.last_of_run)
        else $error("last_of_run misplaced in a token pair");

endmodule

>>> rtl/script_token_scanner.sv
// Top level of the script token scanner: input register, lexer and result queue.
//
// One source byte (or end-of-input mark) is taken per cycle, while s_ready is
// high, into an input register; the lexer works it in one pass and writes its
// zero, one or two tokens into a four-entry result queue, which gives one
// token per cycle while m_ready is high. A new byte can be taken while earlier
// tokens still wait in the queue. A token is registered in the queue before it
// appears on m_data. s_ready drops only when the queue holds more than two
// tokens. Keyword lookup is a parallel compare of the first six identifier
// bytes. No clearing pass after reset.
module script_token_scanner (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  sts_pkg::sts_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output sts_pkg::sts_out_t m_data
);
    import sts_pkg::*;

    sts_in_t    in_reg;
    logic       in_valid_reg;
    logic       room2;
    logic       consume;
    logic [1:0] res_count;
    logic [1:0] push_count;
    sts_out_t   res0, res1;

    assign consume    = in_valid_reg && room2;
    assign s_ready    = !in_valid_reg || consume;
    assign push_count = consume ? res_count : 2'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) in_reg <= s_data;
    end

    sts_lexer u_lexer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (consume),
        .item      (in_reg),
        .res0      (res0),
        .res1      (res1),
        .res_count (res_count)
    );

    sts_res_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_count (push_count),
        .push0      (res0),
        .push1      (res1),
        .room2      (room2),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data)
    );

endmodule
